// ===== sv/ptt_pkg.sv =====
// Shared types, constants and term tables for the propeller thrust/torque block.
package ptt_pkg;

    // Term counts: main polynomial, then the Reynolds corrections
    localparam int ThrustTerms    = 39;
    localparam int TorqueTerms    = 47;
    localparam int MainTerms      = ThrustTerms + TorqueTerms;
    localparam int ReyThrustTerms = 9;
    localparam int ReyTorqueTerms = 13;
    localparam int TermCount      = MainTerms + ReyThrustTerms + ReyTorqueTerms;
    localparam int IdxW           = $clog2(TermCount);

    // Datapath widths
    localparam int MulAW  = 40;
    localparam int MulBW  = 32;
    localparam int ProdW  = MulAW + MulBW;
    localparam int MonoW  = 40;
    localparam int AccW   = 48;
    localparam int LogW   = 28;

    // Fixed numeric constants
    localparam longint unsigned MainDiv = 64'd100000000;
    localparam longint unsigned ReyDiv  = 64'd100000000000;
    localparam logic [MonoW-1:0] OneQ24      = 40'd16777216;
    localparam logic [MulBW-1:0] Log10TwoQ30 = 32'd323228497;
    localparam logic [LogW-1:0]  LogOffset   = 28'd5049942;
    localparam logic [MulBW-1:0] InvPiQ24    = 32'd5340354;
    localparam logic [15:0]      JSmall      = 16'd3;
    localparam logic [31:0]      RnThresh    = 32'd2000000;

    // Configuration register range limits
    localparam logic [14:0] PitchLow  = 15'd8192;
    localparam logic [14:0] PitchHigh = 15'd22938;
    localparam logic [14:0] AreaLow   = 15'd4915;
    localparam logic [14:0] AreaHigh  = 15'd17203;
    localparam logic [2:0]  BladeLow  = 3'd2;
    localparam logic [2:0]  BladeHigh = 3'd7;

    typedef enum logic [1:0] {
        CFG_PITCH  = 2'd0,
        CFG_AREA   = 2'd1,
        CFG_BLADES = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_KT_NEG  = 3'd1,
        STS_KQ_NEG  = 3'd2,
        STS_BAD_CFG = 3'd3,
        STS_KQ_ZERO = 3'd4
    } t_status;

    // Shared multiplier operations: raw product or shift back with rounding or truncation
    typedef enum logic [2:0] {
        MOP_RAW,
        MOP_Q14R,
        MOP_Q15R,
        MOP_Q24R,
        MOP_Q30T,
        MOP_Q30R,
        MOP_COEF
    } t_mop;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_LOG_L10,
        ST_TERM_LOAD,
        ST_TERM_MUL,
        ST_ROUND,
        ST_EFF_MUL1,
        ST_EFF_MUL2,
        ST_EFF_CAP,
        ST_DIV,
        ST_DONE
    } t_state;

    // Exponents of one monomial
    typedef struct packed {
        logic [1:0] j;
        logic [2:0] p;
        logic [1:0] a;
        logic [1:0] z;
        logic [1:0] l;
    } t_exps;

    typedef struct packed {
        longint c;
        t_exps  e;
    } t_term_src;

    function automatic t_term_src mk(longint c, int j, int p, int a, int z, int l);
        t_term_src r;
        r.c   = c;
        r.e.j = 2'(j);
        r.e.p = 3'(p);
        r.e.a = 2'(a);
        r.e.z = 2'(z);
        r.e.l = 2'(l);
        return r;
    endfunction

    // Published coefficients (scaled by 1e8 main, 1e11 Reynolds) and exponents
    function automatic t_term_src term_raw(logic [IdxW-1:0] idx);
        t_term_src r;
        case (idx)
            7'd0:   r = mk(880500, 0, 0, 0, 0, 0);
            7'd1:   r = mk(-20455400, 1, 0, 0, 0, 0);
            7'd2:   r = mk(16635100, 0, 1, 0, 0, 0);
            7'd3:   r = mk(15811400, 0, 2, 0, 0, 0);
            7'd4:   r = mk(-14758100, 2, 0, 1, 0, 0);
            7'd5:   r = mk(-48149700, 1, 1, 1, 0, 0);
            7'd6:   r = mk(41543700, 0, 2, 1, 0, 0);
            7'd7:   r = mk(1440430, 0, 0, 0, 1, 0);
            7'd8:   r = mk(-5300540, 2, 0, 0, 1, 0);
            7'd9:   r = mk(1434810, 0, 1, 0, 1, 0);
            7'd10:  r = mk(6068260, 1, 1, 0, 1, 0);
            7'd11:  r = mk(-1258940, 0, 0, 1, 0, 0);
            7'd12:  r = mk(1096890, 1, 0, 1, 0, 0);
            7'd13:  r = mk(-13369800, 0, 3, 0, 0, 0);
            7'd14:  r = mk(638410, 0, 6, 0, 0, 0);
            7'd15:  r = mk(-132720, 2, 6, 0, 0, 0);
            7'd16:  r = mk(16849600, 3, 0, 1, 0, 0);
            7'd17:  r = mk(-5072140, 0, 0, 2, 0, 0);
            7'd18:  r = mk(8545590, 2, 0, 2, 0, 0);
            7'd19:  r = mk(-5044750, 3, 0, 2, 0, 0);
            7'd20:  r = mk(1046500, 1, 6, 2, 0, 0);
            7'd21:  r = mk(-648270, 2, 6, 2, 0, 0);
            7'd22:  r = mk(-841730, 0, 3, 0, 1, 0);
            7'd23:  r = mk(1684240, 1, 3, 0, 1, 0);
            7'd24:  r = mk(-102300, 3, 3, 0, 1, 0);
            7'd25:  r = mk(-3177910, 0, 3, 1, 1, 0);
            7'd26:  r = mk(1860400, 1, 0, 2, 1, 0);
            7'd27:  r = mk(-410800, 0, 2, 2, 1, 0);
            7'd28:  r = mk(-60680, 0, 0, 0, 2, 0);
            7'd29:  r = mk(-498190, 1, 0, 0, 2, 0);
            7'd30:  r = mk(259830, 2, 0, 0, 2, 0);
            7'd31:  r = mk(-56050, 3, 0, 0, 2, 0);
            7'd32:  r = mk(-163650, 1, 2, 0, 2, 0);
            7'd33:  r = mk(-32880, 1, 6, 0, 2, 0);
            7'd34:  r = mk(11650, 2, 6, 0, 2, 0);
            7'd35:  r = mk(69090, 0, 0, 1, 2, 0);
            7'd36:  r = mk(421750, 0, 3, 1, 2, 0);
            7'd37:  r = mk(5652, 3, 6, 1, 2, 0);
            7'd38:  r = mk(-146560, 0, 3, 2, 2, 0);
            7'd39:  r = mk(379370, 0, 0, 0, 0, 0);
            7'd40:  r = mk(886520, 2, 0, 0, 0, 0);
            7'd41:  r = mk(-3224100, 1, 1, 0, 0, 0);
            7'd42:  r = mk(344780, 0, 2, 0, 0, 0);
            7'd43:  r = mk(-4088110, 0, 1, 1, 0, 0);
            7'd44:  r = mk(-10800900, 1, 1, 1, 0, 0);
            7'd45:  r = mk(-8853810, 2, 1, 1, 0, 0);
            7'd46:  r = mk(18856100, 0, 2, 1, 0, 0);
            7'd47:  r = mk(-370870, 1, 0, 0, 1, 0);
            7'd48:  r = mk(513700, 0, 1, 0, 1, 0);
            7'd49:  r = mk(2094490, 1, 1, 0, 1, 0);
            7'd50:  r = mk(474320, 2, 1, 0, 1, 0);
            7'd51:  r = mk(-723410, 2, 0, 1, 1, 0);
            7'd52:  r = mk(438390, 1, 1, 1, 1, 0);
            7'd53:  r = mk(-2694030, 0, 2, 1, 1, 0);
            7'd54:  r = mk(5580820, 3, 0, 1, 0, 0);
            7'd55:  r = mk(1618860, 0, 3, 1, 0, 0);
            7'd56:  r = mk(318090, 1, 3, 1, 0, 0);
            7'd57:  r = mk(1589600, 0, 0, 2, 0, 0);
            7'd58:  r = mk(4717290, 1, 0, 2, 0, 0);
            7'd59:  r = mk(1962830, 3, 0, 2, 0, 0);
            7'd60:  r = mk(-5027820, 0, 1, 2, 0, 0);
            7'd61:  r = mk(-3005500, 3, 1, 2, 0, 0);
            7'd62:  r = mk(4171220, 2, 2, 2, 0, 0);
            7'd63:  r = mk(-3977220, 0, 3, 2, 0, 0);
            7'd64:  r = mk(-350020, 0, 6, 2, 0, 0);
            7'd65:  r = mk(-1068540, 3, 0, 0, 1, 0);
            7'd66:  r = mk(110900, 3, 3, 0, 1, 0);
            7'd67:  r = mk(-31390, 0, 6, 0, 1, 0);
            7'd68:  r = mk(359850, 3, 0, 1, 1, 0);
            7'd69:  r = mk(-142120, 0, 6, 1, 1, 0);
            7'd70:  r = mk(-383640, 1, 0, 2, 1, 0);
            7'd71:  r = mk(1268030, 0, 2, 2, 1, 0);
            7'd72:  r = mk(-318280, 2, 3, 2, 1, 0);
            7'd73:  r = mk(334270, 0, 6, 2, 1, 0);
            7'd74:  r = mk(-183490, 1, 1, 0, 2, 0);
            7'd75:  r = mk(11250, 3, 2, 0, 2, 0);
            7'd76:  r = mk(-2972, 3, 6, 0, 2, 0);
            7'd77:  r = mk(26960, 1, 0, 1, 2, 0);
            7'd78:  r = mk(83270, 2, 0, 1, 2, 0);
            7'd79:  r = mk(155330, 0, 2, 1, 2, 0);
            7'd80:  r = mk(30270, 0, 6, 1, 2, 0);
            7'd81:  r = mk(-18430, 0, 0, 2, 2, 0);
            7'd82:  r = mk(-42540, 0, 3, 2, 2, 0);
            7'd83:  r = mk(8692, 3, 3, 2, 2, 0);
            7'd84:  r = mk(-46590, 0, 6, 2, 2, 0);
            7'd85:  r = mk(5542, 1, 6, 2, 2, 0);
            7'd86:  r = mk(35348500, 0, 0, 0, 0, 0);
            7'd87:  r = mk(-333758000, 1, 0, 1, 0, 0);
            7'd88:  r = mk(-478125000, 1, 1, 1, 0, 0);
            7'd89:  r = mk(25779200, 2, 0, 1, 0, 2);
            7'd90:  r = mk(6431920, 2, 6, 0, 0, 1);
            7'd91:  r = mk(-1106360, 2, 6, 0, 0, 2);
            7'd92:  r = mk(-2763050, 2, 0, 1, 1, 2);
            7'd93:  r = mk(9540000, 1, 1, 1, 1, 1);
            7'd94:  r = mk(320490, 1, 3, 1, 2, 1);
            7'd95:  r = mk(-59141200, 0, 0, 0, 0, 0);
            7'd96:  r = mk(696898000, 0, 1, 0, 0, 0);
            7'd97:  r = mk(-6666540, 0, 2, 0, 1, 0);
            7'd98:  r = mk(1608180000, 0, 0, 2, 0, 0);
            7'd99:  r = mk(-93809100, 0, 1, 0, 0, 1);
            7'd100: r = mk(-59593000, 0, 2, 0, 0, 1);
            7'd101: r = mk(7820990, 0, 2, 0, 0, 2);
            7'd102: r = mk(521990, 2, 0, 1, 1, 1);
            7'd103: r = mk(-88528, 1, 0, 1, 1, 2);
            7'd104: r = mk(2301710, 0, 6, 0, 1, 1);
            7'd105: r = mk(-184341, 0, 6, 0, 1, 2);
            7'd106: r = mk(-400252000, 0, 0, 2, 0, 1);
            7'd107: r = mk(22091500, 0, 0, 2, 0, 2);
            default: r = mk(0, 0, 0, 0, 0, 0);
        endcase
        return r;
    endfunction

    // Coefficient with fb fraction bits, rounded to nearest on the magnitude
    function automatic longint coef_fixed(logic [IdxW-1:0] idx, int fb);
        t_term_src       s;
        longint unsigned mag;
        longint unsigned q;
        s   = term_raw(idx);
        mag = (s.c < 0) ? longint'(-s.c) : s.c;
        if (idx < IdxW'(MainTerms)) begin
            q = ((mag << fb) + MainDiv / 2) / MainDiv;
        end else begin
            q = ((mag << fb) + ReyDiv / 2) / ReyDiv;
        end
        return (s.c < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Term belongs to the thrust sum
    function automatic logic is_thrust(logic [IdxW-1:0] idx);
        return (idx < IdxW'(ThrustTerms)) ||
               ((idx >= IdxW'(MainTerms)) && (idx < IdxW'(MainTerms + ReyThrustTerms)));
    endfunction

    // Q.24 sum to Q1.22, round half up, saturate
    function automatic logic signed [23:0] sat_q22(logic signed [AccW-1:0] acc);
        logic signed [AccW-1:0] s;
        logic signed [23:0]     r;
        s = (acc + 48'sd2) >>> 2;
        if (s > 48'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (s < -48'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = s[23:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/ptt_rom.sv =====
// Constant term table: scaled coefficient magnitude, sign and exponents.
module ptt_rom #(
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic [ptt_pkg::IdxW-1:0] i_idx,
    output logic [COEF_FRAC_BITS:0]  o_coef_mag,
    output logic                     o_coef_neg,
    output ptt_pkg::t_exps           o_exps
);

    localparam int MagW = COEF_FRAC_BITS + 1;

    logic [MagW-1:0]      w_mag  [ptt_pkg::TermCount];
    logic                 w_neg  [ptt_pkg::TermCount];
    ptt_pkg::t_exps       w_exps [ptt_pkg::TermCount];

    // Coefficients are scaled at elaboration
    for (genvar g = 0; g < ptt_pkg::TermCount; g++) begin : g_term
        localparam ptt_pkg::t_term_src Src = ptt_pkg::term_raw(ptt_pkg::IdxW'(g));
        localparam longint Cf = ptt_pkg::coef_fixed(ptt_pkg::IdxW'(g), COEF_FRAC_BITS);
        assign w_mag[g]  = MagW'((Cf < 0) ? -Cf : Cf);
        assign w_neg[g]  = (Cf < 0);
        assign w_exps[g] = Src.e;
    end

    // Table read
    assign o_coef_mag = w_mag[i_idx];
    assign o_coef_neg = w_neg[i_idx];
    assign o_exps     = w_exps[i_idx];

endmodule

// ===== sv/ptt_mul.sv =====
// Shared multiplier with the fixed-point shift-back and rounding options.
module ptt_mul #(
    parameter int COEF_FRAC_BITS = 24
) (
    input  ptt_pkg::t_mop              i_op,
    input  logic [ptt_pkg::MulAW-1:0]  i_a,
    input  logic [ptt_pkg::MulBW-1:0]  i_b,
    output logic [ptt_pkg::ProdW-1:0]  o_res
);

    localparam int PW        = ptt_pkg::ProdW;
    localparam int CoefShift = COEF_FRAC_BITS - 8;

    logic [PW-1:0] w_prod;
    logic [PW:0]   w_sum;

    assign w_prod = {{ptt_pkg::MulBW{1'b0}}, i_a} * {{ptt_pkg::MulAW{1'b0}}, i_b};

    // Shift back to the working format
    always_comb begin
        w_sum = '0;
        o_res = w_prod;
        case (i_op)
            ptt_pkg::MOP_RAW: begin
                o_res = w_prod;
            end
            ptt_pkg::MOP_Q14R: begin
                w_sum = {1'b0, w_prod} + ((PW+1)'(1) << 13);
                o_res = PW'(w_sum >> 14);
            end
            ptt_pkg::MOP_Q15R: begin
                w_sum = {1'b0, w_prod} + ((PW+1)'(1) << 14);
                o_res = PW'(w_sum >> 15);
            end
            ptt_pkg::MOP_Q24R: begin
                w_sum = {1'b0, w_prod} + ((PW+1)'(1) << 23);
                o_res = PW'(w_sum >> 24);
            end
            ptt_pkg::MOP_Q30T: begin
                o_res = w_prod >> 30;
            end
            ptt_pkg::MOP_Q30R: begin
                w_sum = {1'b0, w_prod} + ((PW+1)'(1) << 29);
                o_res = PW'(w_sum >> 30);
            end
            ptt_pkg::MOP_COEF: begin
                o_res = w_prod >> CoefShift;
            end
            default: begin
                o_res = w_prod;
            end
        endcase
    end

endmodule

// ===== sv/propeller_thrust_torque_coefficients.sv =====
// Top level: Wageningen B-series KT/KQ evaluation with one shared multiplier.
//
// Input channel: i_in_valid / o_in_stall carry J (Q1.15) and Rn; a transaction
// takes place when valid is high and stall is low. Output channel:
// o_out_valid / i_out_stall carry KT, KQ (Q1.22), efficiency (Q0.16), status.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 pitch ratio, 1 area ratio, 2 blade count); other indexes are ignored.
//
// Each item is worked one at a time by a sequencer around a single multiplier.
// For Rn > 2e6 it first forms log10 Rn by normalising shifts and one squaring
// per fraction bit. For each evaluated term it loads the entry, multiplies in
// one exponent factor at a time and then the coefficient. It rounds both sums,
// then forms the efficiency by two multiplies and 16 restoring divide steps,
// cut short when the quotient saturates, KT or KQ is negative or KQ is zero.
// o_in_stall is high from acceptance until the result is moved to the output
// register, so the next item is taken while a result still waits downstream.
// If the receiver stalls, the result holds and the sequencer waits at its end.
// Reset (synchronous, active low) clears the sequencer and output valid and
// restores the configuration defaults; the term tables are constant.
module propeller_thrust_torque_coefficients #(
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_advance_ratio,
    input  logic [31:0]        i_reynolds_number,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [23:0] o_thrust_coef,
    output logic signed [23:0] o_torque_coef,
    output logic [15:0]        o_open_water_eff,
    output logic [2:0]         o_status
);

    localparam int IW = ptt_pkg::IdxW;
    localparam int AW = ptt_pkg::AccW;

    // Configuration
    logic [14:0] r_pitch;
    logic [14:0] r_area;
    logic [2:0]  r_blades;

    // Sequencer and datapath
    ptt_pkg::t_state r_state;
    ptt_pkg::t_state n_state;
    logic [15:0]             r_jin;
    logic [15:0]             r_jv;
    logic                    r_rey;
    logic [31:0]             r_x;
    logic [4:0]              r_k;
    logic [23:0]             r_frac;
    logic [4:0]              r_cnt;
    logic [ptt_pkg::LogW-1:0] r_lv;
    logic [IW-1:0]           r_idx;
    ptt_pkg::t_exps          r_exps;
    logic [ptt_pkg::MonoW-1:0] r_m;
    logic signed [AW-1:0]    r_acc_kt;
    logic signed [AW-1:0]    r_acc_kq;
    logic signed [23:0]      r_kt;
    logic signed [23:0]      r_kq;
    logic [63:0]             r_num;
    logic [63:0]             r_dsh;
    logic [15:0]             r_q;

    // Output register
    logic                    r_out_valid;
    logic signed [23:0]      r_out_kt;
    logic signed [23:0]      r_out_kq;
    logic [15:0]             r_out_eff;
    ptt_pkg::t_status        r_out_status;

    // Shared unit and table
    ptt_pkg::t_mop               w_mop;
    logic [ptt_pkg::MulAW-1:0]   w_ma;
    logic [ptt_pkg::MulBW-1:0]   w_mb;
    logic [ptt_pkg::ProdW-1:0]   w_res;
    logic [COEF_FRAC_BITS:0]     w_coef_mag;
    logic                        w_coef_neg;
    ptt_pkg::t_exps              w_rom_exps;

    logic                    w_any_exp;
    logic                    w_term_last;
    logic [32:0]             w_sq;
    logic [AW-1:0]           w_term;
    logic signed [AW-1:0]    w_tval;
    logic                    w_eff_ok;
    logic [63:0]             w_dlim;
    logic                    w_out_free;
    logic                    w_bad_cfg;
    ptt_pkg::t_status        w_status;

    ptt_rom #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_rom (
        .i_idx      (r_idx),
        .o_coef_mag (w_coef_mag),
        .o_coef_neg (w_coef_neg),
        .o_exps     (w_rom_exps)
    );

    ptt_mul #(
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_mul (
        .i_op  (w_mop),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_res (w_res)
    );

    // Handshake and misc decode
    assign o_in_stall  = (r_state != ptt_pkg::ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_any_exp   = |{r_exps.l, r_exps.j, r_exps.p, r_exps.a, r_exps.z};
    assign w_term_last = ((r_idx == IW'(ptt_pkg::MainTerms - 1)) && !r_rey) ||
                         (r_idx == IW'(ptt_pkg::TermCount - 1));
    assign w_sq        = w_res[32:0];
    assign w_term      = w_res[AW-1:0];
    assign w_tval      = w_coef_neg ? -$signed(w_term) : $signed(w_term);
    assign w_eff_ok    = !r_kt[23] && !r_kq[23] && (r_kq != 24'sd0);
    assign w_dlim      = {r_kq, 40'b0};

    // Configuration range check and status code
    assign w_bad_cfg = (r_pitch < ptt_pkg::PitchLow) || (r_pitch > ptt_pkg::PitchHigh) ||
                       (r_area < ptt_pkg::AreaLow) || (r_area > ptt_pkg::AreaHigh) ||
                       (r_blades < ptt_pkg::BladeLow) || (r_blades > ptt_pkg::BladeHigh);

    always_comb begin
        if (w_bad_cfg) begin
            w_status = ptt_pkg::STS_BAD_CFG;
        end else if (r_kt[23]) begin
            w_status = ptt_pkg::STS_KT_NEG;
        end else if (r_kq[23]) begin
            w_status = ptt_pkg::STS_KQ_NEG;
        end else if (r_kq == 24'sd0) begin
            w_status = ptt_pkg::STS_KQ_ZERO;
        end else begin
            w_status = ptt_pkg::STS_OK;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch  <= 15'd16384;
            r_area   <= 15'd9830;
            r_blades <= 3'd4;
        end else if (i_cfg_we) begin
            case (ptt_pkg::t_cfg_idx'(i_cfg_index))
                ptt_pkg::CFG_PITCH:  r_pitch  <= i_cfg_data;
                ptt_pkg::CFG_AREA:   r_area   <= i_cfg_data;
                ptt_pkg::CFG_BLADES: r_blades <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_reynolds_number > ptt_pkg::RnThresh) ?
                              ptt_pkg::ST_LOG_NORM : ptt_pkg::ST_TERM_LOAD;
                end
            end
            ptt_pkg::ST_LOG_NORM: begin
                if (r_x[31]) n_state = ptt_pkg::ST_LOG_SQ;
            end
            ptt_pkg::ST_LOG_SQ: begin
                if (r_cnt == 5'd23) n_state = ptt_pkg::ST_LOG_L10;
            end
            ptt_pkg::ST_LOG_L10:   n_state = ptt_pkg::ST_TERM_LOAD;
            ptt_pkg::ST_TERM_LOAD: n_state = ptt_pkg::ST_TERM_MUL;
            ptt_pkg::ST_TERM_MUL: begin
                if (!w_any_exp) begin
                    n_state = w_term_last ? ptt_pkg::ST_ROUND : ptt_pkg::ST_TERM_LOAD;
                end
            end
            ptt_pkg::ST_ROUND:    n_state = ptt_pkg::ST_EFF_MUL1;
            ptt_pkg::ST_EFF_MUL1: begin
                n_state = w_eff_ok ? ptt_pkg::ST_EFF_MUL2 : ptt_pkg::ST_DONE;
            end
            ptt_pkg::ST_EFF_MUL2: n_state = ptt_pkg::ST_EFF_CAP;
            ptt_pkg::ST_EFF_CAP: begin
                n_state = (r_num >= w_dlim) ? ptt_pkg::ST_DONE : ptt_pkg::ST_DIV;
            end
            ptt_pkg::ST_DIV: begin
                if (r_cnt == 5'd15) n_state = ptt_pkg::ST_DONE;
            end
            ptt_pkg::ST_DONE: begin
                if (w_out_free) n_state = ptt_pkg::ST_IDLE;
            end
            default: n_state = ptt_pkg::ST_IDLE;
        endcase
    end

    // Multiplier operand selection
    always_comb begin
        w_mop = ptt_pkg::MOP_RAW;
        w_ma  = '0;
        w_mb  = '0;
        case (r_state)
            ptt_pkg::ST_LOG_SQ: begin
                w_mop = ptt_pkg::MOP_Q30T;
                w_ma  = {8'b0, r_x};
                w_mb  = r_x;
            end
            ptt_pkg::ST_LOG_L10: begin
                w_mop = ptt_pkg::MOP_Q30R;
                w_ma  = {11'b0, r_k, r_frac};
                w_mb  = ptt_pkg::Log10TwoQ30;
            end
            ptt_pkg::ST_TERM_MUL: begin
                w_ma = r_m;
                if (r_exps.l != 2'd0) begin
                    w_mop = ptt_pkg::MOP_Q24R;
                    w_mb  = {4'b0, r_lv};
                end else if (r_exps.j != 2'd0) begin
                    w_mop = ptt_pkg::MOP_Q15R;
                    w_mb  = {16'b0, r_jv};
                end else if (r_exps.p != 3'd0) begin
                    w_mop = ptt_pkg::MOP_Q14R;
                    w_mb  = {17'b0, r_pitch};
                end else if (r_exps.a != 2'd0) begin
                    w_mop = ptt_pkg::MOP_Q14R;
                    w_mb  = {17'b0, r_area};
                end else if (r_exps.z != 2'd0) begin
                    w_mop = ptt_pkg::MOP_RAW;
                    w_mb  = {29'b0, r_blades};
                end else begin
                    // coefficient times monomial
                    w_mop = ptt_pkg::MOP_COEF;
                    w_ma  = ptt_pkg::MulAW'(w_coef_mag);
                    w_mb  = r_m[39:8];
                end
            end
            ptt_pkg::ST_EFF_MUL1: begin
                w_ma = {16'b0, r_kt};
                w_mb = {16'b0, r_jin};
            end
            ptt_pkg::ST_EFF_MUL2: begin
                w_ma = r_num[39:0];
                w_mb = ptt_pkg::InvPiQ24;
            end
            default: ;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ptt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    r_jin    <= i_advance_ratio;
                    r_jv     <= (i_advance_ratio == 16'd0) ? ptt_pkg::JSmall : i_advance_ratio;
                    r_rey    <= (i_reynolds_number > ptt_pkg::RnThresh);
                    r_x      <= i_reynolds_number;
                    r_k      <= 5'd31;
                    r_frac   <= '0;
                    r_cnt    <= '0;
                    r_idx    <= '0;
                    r_acc_kt <= '0;
                    r_acc_kq <= '0;
                end
            end
            // normalise Rn to Q1.30, tracking the top set bit
            ptt_pkg::ST_LOG_NORM: begin
                if (r_x[31]) begin
                    r_x <= r_x >> 1;
                end else begin
                    r_x <= r_x << 1;
                    r_k <= r_k - 5'd1;
                end
            end
            // one fraction bit of log2 per squaring
            ptt_pkg::ST_LOG_SQ: begin
                r_cnt <= r_cnt + 5'd1;
                if (w_sq[32:31] != 2'b00) begin
                    r_x    <= w_sq[32:1];
                    r_frac <= {r_frac[22:0], 1'b1};
                end else begin
                    r_x    <= w_sq[31:0];
                    r_frac <= {r_frac[22:0], 1'b0};
                end
            end
            ptt_pkg::ST_LOG_L10: begin
                r_lv <= w_res[ptt_pkg::LogW-1:0] - ptt_pkg::LogOffset;
            end
            ptt_pkg::ST_TERM_LOAD: begin
                r_exps <= w_rom_exps;
                r_m    <= ptt_pkg::OneQ24;
            end
            // one factor per cycle, then the scaled term into its sum
            ptt_pkg::ST_TERM_MUL: begin
                if (w_any_exp) begin
                    r_m <= w_res[ptt_pkg::MonoW-1:0];
                    if (r_exps.l != 2'd0) begin
                        r_exps.l <= r_exps.l - 2'd1;
                    end else if (r_exps.j != 2'd0) begin
                        r_exps.j <= r_exps.j - 2'd1;
                    end else if (r_exps.p != 3'd0) begin
                        r_exps.p <= r_exps.p - 3'd1;
                    end else if (r_exps.a != 2'd0) begin
                        r_exps.a <= r_exps.a - 2'd1;
                    end else begin
                        r_exps.z <= r_exps.z - 2'd1;
                    end
                end else begin
                    r_idx <= r_idx + IW'(1);
                    if (ptt_pkg::is_thrust(r_idx)) begin
                        r_acc_kt <= r_acc_kt + w_tval;
                    end else begin
                        r_acc_kq <= r_acc_kq + w_tval;
                    end
                end
            end
            ptt_pkg::ST_ROUND: begin
                r_kt <= ptt_pkg::sat_q22(r_acc_kt);
                r_kq <= ptt_pkg::sat_q22(r_acc_kq);
            end
            ptt_pkg::ST_EFF_MUL1: begin
                r_num <= w_res[63:0];
                r_q   <= '0;
            end
            ptt_pkg::ST_EFF_MUL2: begin
                r_num <= w_res[63:0] + ({40'b0, r_kq} << 23);
            end
            ptt_pkg::ST_EFF_CAP: begin
                if (r_num >= w_dlim) begin
                    r_q <= 16'hFFFF;
                end else begin
                    r_dsh <= {1'b0, r_kq, 39'b0};
                    r_cnt <= '0;
                end
            end
            // restoring divide, one quotient bit per cycle
            ptt_pkg::ST_DIV: begin
                r_cnt <= r_cnt + 5'd1;
                r_dsh <= r_dsh >> 1;
                if (r_num >= r_dsh) begin
                    r_num <= r_num - r_dsh;
                    r_q   <= {r_q[14:0], 1'b1};
                end else begin
                    r_q   <= {r_q[14:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ptt_pkg::ST_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ptt_pkg::ST_DONE) && w_out_free) begin
            r_out_kt     <= r_kt;
            r_out_kq     <= r_kq;
            r_out_eff    <= r_q;
            r_out_status <= w_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_thrust_coef    = r_out_kt;
    assign o_torque_coef    = r_out_kq;
    assign o_open_water_eff = r_out_eff;
    assign o_status         = r_out_status;

    // Mantissa stays normalised through the squaring steps
    a_log_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptt_pkg::ST_LOG_SQ) |-> (r_x[31:30] == 2'b01))
        else $error("log mantissa out of [1,2)");

    // Remainder below twice the shifted divisor keeps quotient bits single
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptt_pkg::ST_DIV) |-> (r_num < {r_dsh[62:0], 1'b0}))
        else $error("divide remainder too large");

    // A result appears only from the final sequencer step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ptt_pkg::ST_DONE))
        else $error("output loaded outside final step");

    // An accepted transaction leaves the idle state
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted item did not start");

endmodule
